FILE: rtl/keycode_to_ascii_line_editor_top_assert.svh
`ifndef KEYCODE_TO_ASCII_LINE_EDITOR_TOP_ASSERT_SVH
`define KEYCODE_TO_ASCII_LINE_EDITOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KCLE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("kcle: check failed");

// next-cycle implication
`define KCLE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("kcle: check failed");

`endif

FILE: rtl/kcle_pkg.sv
`default_nettype none
package kcle_pkg;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_ERASE,
    ACT_LINE_END,
    ACT_CTRL,
    ACT_ALT,
    ACT_ARROW,
    ACT_FULL
  } act_e;

  typedef enum logic [2:0] {
    REG_ECHO,
    REG_CURSOR,
    REG_CAPTURE,
    REG_FORWARD,
    REG_BLINK
  } reg_e;

  localparam int ADDR_W = 5;

  localparam logic [4:0]  EV_KEY     = 5'd1;
  localparam logic [7:0]  KC_BKSP    = 8'd14;
  localparam logic [7:0]  KC_ENTER   = 8'd28;
  localparam logic [7:0]  KC_LCTRL   = 8'd29;
  localparam logic [7:0]  KC_LSHIFT  = 8'd42;
  localparam logic [7:0]  KC_RSHIFT  = 8'd54;
  localparam logic [7:0]  KC_LALT    = 8'd56;
  localparam logic [7:0]  KC_SPACE   = 8'd57;
  localparam logic [7:0]  KC_UP      = 8'd72;
  localparam logic [7:0]  KC_LEFT    = 8'd75;
  localparam logic [7:0]  KC_RIGHT   = 8'd77;
  localparam logic [7:0]  KC_DOWN    = 8'd80;
  localparam logic [7:0]  KC_RCTRL   = 8'd97;
  localparam logic [7:0]  KC_RALT    = 8'd100;
  localparam logic [6:0]  CH_BS      = 7'd8;
  localparam logic [23:0] BLINK_RST  = 24'd1000000;

  localparam logic [8*24-1:0] ROW_NUM = "1234567890-=!@#$%^&*()_+";
  localparam logic [8*24-1:0] ROW_Q   = "qwertyuiop[]QWERTYUIOP{}";
  localparam logic [8*24-1:0] ROW_A   = "asdfghjkl;'\\ASDFGHJKL:\"|";
  localparam logic [8*20-1:0] ROW_Z   = "zxcvbnm,./ZXCVBNM<>?";

  typedef struct packed {
    logic        echo;
    logic        cursor;
    logic        capture;
    logic        fwd;
    logic [23:0] period;
  } cfg_t;

  typedef struct packed {
    act_e       action;
    logic [6:0] ch;
    logic [8:0] pos;
    logic [7:0] fwd;
    logic       echo;
    logic       draw;
    logic       erase;
  } res_t;

  // {mapped, ascii}
  function automatic logic [7:0] map_char(input logic [7:0] c, input logic sh);
    logic [4:0] idx;
    logic [7:0] b;
    logic       has;
    idx = '0;
    b   = '0;
    has = 1'b0;
    if (c == KC_SPACE) begin
      b   = 8'h20;
      has = 1'b1;
    end else if (c >= 8'd2 && c <= 8'd13) begin
      idx = 5'(c - 8'd2) + (sh ? 5'd12 : 5'd0);
      b   = ROW_NUM[8*(23 - int'(idx)) +: 8];
      has = 1'b1;
    end else if (c >= 8'd16 && c <= 8'd27) begin
      idx = 5'(c - 8'd16) + (sh ? 5'd12 : 5'd0);
      b   = ROW_Q[8*(23 - int'(idx)) +: 8];
      has = 1'b1;
    end else if (c >= 8'd30 && c <= 8'd41) begin
      idx = 5'(c - 8'd30) + (sh ? 5'd12 : 5'd0);
      b   = ROW_A[8*(23 - int'(idx)) +: 8];
      has = 1'b1;
    end else if (c >= 8'd44 && c <= 8'd53) begin
      idx = 5'(c - 8'd44) + (sh ? 5'd10 : 5'd0);
      b   = ROW_Z[8*(19 - int'(idx)) +: 8];
      has = 1'b1;
    end
    return {has, b[6:0]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kcle_ram.sv
`default_nettype none
module kcle_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 255
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kcle_cfg.sv
`default_nettype none
module kcle_cfg
  import kcle_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (sel)
        REG_ECHO:    cfg_d.echo    = pwdata[0];
        REG_CURSOR:  cfg_d.cursor  = pwdata[0];
        REG_CAPTURE: cfg_d.capture = pwdata[0];
        REG_FORWARD: cfg_d.fwd     = pwdata[0];
        REG_BLINK:   cfg_d.period  = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ECHO:    prdata = {31'd0, cfg_q.echo};
      REG_CURSOR:  prdata = {31'd0, cfg_q.cursor};
      REG_CAPTURE: prdata = {31'd0, cfg_q.capture};
      REG_FORWARD: prdata = {31'd0, cfg_q.fwd};
      REG_BLINK:   prdata = {8'd0, cfg_q.period};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo    <= 1'b1;
      cfg_q.cursor  <= 1'b0;
      cfg_q.capture <= 1'b1;
      cfg_q.fwd     <= 1'b1;
      cfg_q.period  <= BLINK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kcle_core.sv
`default_nettype none
module kcle_core
  import kcle_pkg::*;
#(
  parameter int LINE_LEN  = 256,
  parameter int KEY_COUNT = 255
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire cfg_t                         cfg_i,
  input  wire logic [4:0]                   event_type_i,
  input  wire logic [7:0]                   key_code_i,
  input  wire logic [1:0]                   key_value_i,
  input  wire logic [1:0]                   kt_data_i,
  output res_t                              res_o,
  output logic                              kt_we_o,
  output logic      [$clog2(KEY_COUNT)-1:0] kt_waddr_o,
  output logic      [1:0]                   kt_wdata_o
);

  localparam int KW = $clog2(KEY_COUNT);
  localparam int LW = $clog2(LINE_LEN + 1);
  localparam int PW = (LW > 9) ? LW : 9;
  localparam int M_LCTRL = 0;
  localparam int M_RCTRL = 1;
  localparam int M_LALT  = 2;
  localparam int M_RALT  = 3;
  localparam int M_LSH   = 4;
  localparam int M_RSH   = 5;

  logic [KEY_COUNT-1:0] kvalid_q;
  logic [5:0]           mod_q, mod_d;
  logic                 last_valid_q, last_valid_d;
  logic [4:0]           last_t_q, last_t_d;
  logic [7:0]           last_c_q, last_c_d;
  logic [1:0]           last_v_q, last_v_d;
  logic                 blink_act_q, blink_act_d;
  logic [24:0]          blink_cnt_q, blink_cnt_d;
  logic [LW-1:0]        line_q, line_d;
  logic [PW-1:0]        pos_ext;

  logic [KW-1:0] idx;
  logic          in_range;
  logic [1:0]    kv;
  logic          same;
  logic [24:0]   half;
  logic [7:0]    mapped;
  logic          is_new, ctrl, alt, arrow, rec, kput, kt_we;

  assign idx      = key_code_i[KW-1:0];
  assign in_range = {1'b0, key_code_i} < 9'(KEY_COUNT);
  assign kv       = (in_range && kvalid_q[idx]) ? kt_data_i : 2'd0;
  assign same     = last_valid_q && event_type_i == last_t_q && key_code_i == last_c_q
                    && key_value_i == last_v_q;
  assign half     = {2'b00, cfg_i.period[23:1]};
  assign mapped   = map_char(key_code_i, mod_q[M_LSH] | mod_q[M_RSH]);
  assign is_new   = key_value_i != 2'd0 && kv != key_value_i;
  assign ctrl     = mod_q[M_LCTRL] | mod_q[M_RCTRL];
  assign alt      = mod_q[M_LALT] | mod_q[M_RALT];
  assign arrow    = key_code_i == KC_UP || key_code_i == KC_DOWN
                    || key_code_i == KC_LEFT || key_code_i == KC_RIGHT;

  always_comb begin
    res_o        = '0;
    res_o.action = ACT_NONE;
    blink_act_d  = blink_act_q;
    blink_cnt_d  = blink_cnt_q;
    last_valid_d = last_valid_q;
    last_t_d     = last_t_q;
    last_c_d     = last_c_q;
    last_v_d     = last_v_q;
    line_d       = line_q;
    rec          = 1'b0;
    kput         = 1'b0;

    if (cfg_i.echo && cfg_i.cursor) begin
      if (same) begin
        if (!blink_act_q) begin
          blink_act_d = 1'b1;
          blink_cnt_d = '0;
        end else if (blink_cnt_q == '0) begin
          res_o.draw  = 1'b1;
          blink_cnt_d = blink_cnt_q + 25'd1;
        end else if (blink_cnt_q == half) begin
          res_o.erase = 1'b1;
          blink_cnt_d = blink_cnt_q + 25'd1;
        end else if (blink_cnt_q > {1'b0, cfg_i.period}) begin
          blink_cnt_d = '0;
        end else begin
          blink_cnt_d = blink_cnt_q + 25'd1;
        end
      end else begin
        res_o.erase = blink_act_q && blink_cnt_q != '0 && blink_cnt_q < half;
        blink_act_d = 1'b0;
        blink_cnt_d = '0;
      end
    end

    if (event_type_i == EV_KEY) begin
      rec = 1'b1;
      if (is_new) begin
        if (ctrl) begin
          if (cfg_i.fwd) begin
            res_o.action = ACT_CTRL;
            res_o.fwd    = key_code_i;
          end
          rec = 1'b0;
        end else if (alt) begin
          if (cfg_i.fwd) begin
            res_o.action = ACT_ALT;
            res_o.fwd    = key_code_i;
          end
          rec = 1'b0;
        end else if (!cfg_i.capture) begin
          kput = 1'b1;
          rec  = 1'b0;
        end else if (key_code_i == KC_ENTER) begin
          res_o.action = ACT_LINE_END;
          rec          = 1'b0;
        end else if (key_code_i == KC_BKSP) begin
          if (line_q != '0) begin
            res_o.action = ACT_ERASE;
            res_o.ch     = CH_BS;
            res_o.echo   = cfg_i.echo;
            line_d       = line_q - LW'(1);
          end
        end else if (arrow) begin
          kput = 1'b1;
          if (cfg_i.fwd) begin
            res_o.action = ACT_ARROW;
            res_o.fwd    = key_code_i;
            rec          = 1'b0;
          end
        end else if (mapped[7]) begin
          res_o.ch = mapped[6:0];
          if (line_q >= LW'(LINE_LEN)) begin
            res_o.action = ACT_FULL;
          end else begin
            res_o.action = ACT_APPEND;
            res_o.echo   = cfg_i.echo;
            line_d       = line_q + LW'(1);
          end
        end
      end
      if (rec) begin
        last_valid_d = 1'b1;
        last_t_d     = event_type_i;
        last_c_d     = key_code_i;
        last_v_d     = key_value_i;
        kput         = 1'b1;
      end
    end

    pos_ext   = PW'(line_d);
    res_o.pos = pos_ext[8:0];
  end

  assign kt_we      = kput && in_range;
  assign kt_we_o    = fire_i && kt_we;
  assign kt_waddr_o = idx;
  assign kt_wdata_o = key_value_i;

  always_comb begin
    mod_d = mod_q;
    if (kt_we) begin
      case (key_code_i)
        KC_LCTRL:  mod_d[M_LCTRL] = key_value_i != 2'd0;
        KC_RCTRL:  mod_d[M_RCTRL] = key_value_i != 2'd0;
        KC_LALT:   mod_d[M_LALT]  = key_value_i != 2'd0;
        KC_RALT:   mod_d[M_RALT]  = key_value_i != 2'd0;
        KC_LSHIFT: mod_d[M_LSH]   = key_value_i != 2'd0;
        KC_RSHIFT: mod_d[M_RSH]   = key_value_i != 2'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q     <= '0;
      mod_q        <= '0;
      last_valid_q <= 1'b0;
      last_t_q     <= '0;
      last_c_q     <= '0;
      last_v_q     <= '0;
      blink_act_q  <= 1'b0;
      blink_cnt_q  <= '0;
      line_q       <= '0;
    end else if (fire_i) begin
      if (kt_we) begin
        kvalid_q[idx] <= 1'b1;
      end
      mod_q        <= mod_d;
      last_valid_q <= last_valid_d;
      last_t_q     <= last_t_d;
      last_c_q     <= last_c_d;
      last_v_q     <= last_v_d;
      blink_act_q  <= blink_act_d;
      blink_cnt_q  <= blink_cnt_d;
      line_q       <= line_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/keycode_to_ascii_line_editor_top.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    event_type_i, key_code_i, key_value_i
// out       out_valid_o / out_ready_i  action_o, char_code_o, line_position_o,
//                                      forward_code_o, echo_o, cursor_draw_o, cursor_erase_o
// cfg       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One request per cycle sustained while out_ready_i is high; results are registered out of stage 2.
// Stage 1 reads the key-state RAM, stage 2 updates state and writes the entry back;
// a bypass register covers a write to the same key in the read cycle.
// Reset is asynchronous; per-key valid flops make every key read as released, no clear pass.
// A stalled output holds stage 2; in_ready_o drops only while stage 2 and the
// output register are both occupied and out_ready_i is low.
`default_nettype none
module keycode_to_ascii_line_editor_top
  import kcle_pkg::*;
#(
  parameter int LINE_LEN  = 256,
  parameter int KEY_COUNT = 255
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [4:0]        event_type_i,
  input  wire logic [7:0]        key_code_i,
  input  wire logic [1:0]        key_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [2:0]        action_o,
  output logic      [6:0]        char_code_o,
  output logic      [8:0]        line_position_o,
  output logic      [7:0]        forward_code_o,
  output logic                   echo_o,
  output logic                   cursor_draw_o,
  output logic                   cursor_erase_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int KW = $clog2(KEY_COUNT);

  cfg_t cfg;

  logic       s1_valid_q, s1_valid_d;
  logic [4:0] s1_t_q;
  logic [7:0] s1_c_q;
  logic [1:0] s1_v_q;
  logic       hit_q;
  logic [1:0] byp_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_q, res;

  logic          accept, fire;
  logic [1:0]    rdata, kt_data;
  logic          kt_we;
  logic [KW-1:0] kt_waddr;
  logic [1:0]    kt_wdata;

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;
  assign kt_data    = hit_q ? byp_q : rdata;

  assign s1_valid_d  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  kcle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kcle_ram #(
    .WIDTH (2),
    .DEPTH (KEY_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kt_we),
    .waddr_i (kt_waddr),
    .wdata_i (kt_wdata),
    .re_i    (accept),
    .raddr_i (key_code_i[KW-1:0]),
    .rdata_o (rdata)
  );

  kcle_core #(
    .LINE_LEN  (LINE_LEN),
    .KEY_COUNT (KEY_COUNT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cfg_i        (cfg),
    .event_type_i (s1_t_q),
    .key_code_i   (s1_c_q),
    .key_value_i  (s1_v_q),
    .kt_data_i    (kt_data),
    .res_o        (res),
    .kt_we_o      (kt_we),
    .kt_waddr_o   (kt_waddr),
    .kt_wdata_o   (kt_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_t_q <= event_type_i;
      s1_c_q <= key_code_i;
      s1_v_q <= key_value_i;
      hit_q  <= kt_we && kt_waddr == key_code_i[KW-1:0];
      byp_q  <= kt_wdata;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_q.action;
  assign char_code_o     = out_q.ch;
  assign line_position_o = out_q.pos;
  assign forward_code_o  = out_q.fwd;
  assign echo_o          = out_q.echo;
  assign cursor_draw_o   = out_q.draw;
  assign cursor_erase_o  = out_q.erase;

endmodule
`default_nettype wire

FILE: rtl/kcle_sva.sv
`default_nettype none
`include "keycode_to_ascii_line_editor_top_assert.svh"
module kcle_sva
  import kcle_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] action_o,
  input wire logic [6:0] char_code_o,
  input wire logic [8:0] line_position_o,
  input wire logic [7:0] forward_code_o,
  input wire logic       echo_o,
  input wire logic       cursor_draw_o,
  input wire logic       cursor_erase_o
);

  `KCLE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(action_o) && $stable(char_code_o) && $stable(line_position_o) && $stable(forward_code_o))

  `KCLE_ASSERT_NOW(a_ready_full, !in_ready_o, out_valid_o)

  `KCLE_ASSERT_NOW(a_echo_act, out_valid_o && echo_o, action_o == ACT_APPEND || action_o == ACT_ERASE)

  `KCLE_ASSERT_NOW(a_fwd_act, out_valid_o && action_o != ACT_CTRL && action_o != ACT_ALT && action_o != ACT_ARROW, forward_code_o == 8'd0)

  `KCLE_ASSERT_NOW(a_cursor_excl, out_valid_o, !(cursor_draw_o && cursor_erase_o))

endmodule

bind keycode_to_ascii_line_editor_top kcle_sva u_sva (.*);
`default_nettype wire
